@@ design/ps2mc_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet cursor.
package ps2mc_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned SizeBits  = 13;
  localparam int unsigned SumBits   = CoordBits + 2;

  localparam logic [SizeBits-1:0]  ResetWidth  = 13'd640;
  localparam logic [SizeBits-1:0]  ResetHeight = 13'd480;
  localparam logic [CoordBits-1:0] ResetPosX   = CoordBits'(ResetWidth / 2);
  localparam logic [CoordBits-1:0] ResetPosY   = CoordBits'(ResetHeight / 2);
  localparam logic [CoordBits-1:0] CoordMax    = '1;

  localparam int unsigned SyncBit = 3;
  localparam logic [2:0]  BtnMask = 3'b111;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    CMD_KEEP = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_DROP = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } cmd_t;

  typedef struct packed {
    logic [SizeBits-1:0] width;
    logic [SizeBits-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0] cursor_x;
    logic [CoordBits-1:0] cursor_y;
    logic [2:0]           button_bits;
    logic                 packet_done;
    logic                 byte_dropped;
  } res_t;

endpackage

@@ design/ps2mc_fifo.sv @@
// Small first-word-fall-through queue built from registers.
module ps2mc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2   // power of two, at least 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("queue count exceeds depth");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !push_i) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("queue count did not drop on a lone pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == DepthC) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

@@ design/ps2mc_front.sv @@
// Packet framer: tracks the byte phase and turns each byte into a command.
module ps2mc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          cmd_valid_o,
  output ps2mc_pkg::cmd_t cmd_o
);

  import ps2mc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] hdr_q, hdr_d;
  logic [7:0] dx_q, dx_d;

  assign cmd_valid_o = byte_valid_i;

  always_comb begin
    phase_d      = phase_q;
    hdr_d        = hdr_q;
    dx_d         = dx_q;
    cmd_o.kind    = CMD_KEEP;
    cmd_o.buttons = hdr_q;
    cmd_o.dx      = dx_q;
    cmd_o.dy      = byte_i;
    unique case (phase_q)
      PH_DX: begin
        dx_d    = byte_i;
        phase_d = PH_DY;
      end
      PH_DY: begin
        cmd_o.kind = CMD_MOVE;
        phase_d    = PH_HEAD;
      end
      default: begin
        // A header must carry the always-one bit, else it is thrown away.
        if (byte_i[SyncBit]) begin
          hdr_d   = byte_i[2:0] & BtnMask;
          phase_d = PH_DX;
        end else begin
          cmd_o.kind = CMD_DROP;
          phase_d    = PH_HEAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      hdr_q   <= '0;
      dx_q    <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
    end
  end

endmodule

@@ design/ps2mc_back.sv @@
// Cursor engine: applies commands to the clamped position and forms results.
module ps2mc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ps2mc_pkg::cfg_t cfg_i,
  input  logic            cmd_valid_i,
  input  ps2mc_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_ready_i,
  output logic            res_valid_o,
  output ps2mc_pkg::res_t res_o
);

  import ps2mc_pkg::*;

  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;
  logic [2:0]           btn_q, btn_d;
  logic [CoordBits-1:0] lim_x, lim_y;
  logic [CoordBits-1:0] new_x, new_y;
  logic                 fire, move;

  function automatic logic [CoordBits-1:0] limit_of(input logic [SizeBits-1:0] size);
    logic [SizeBits-1:0] size_m1;
    size_m1 = size - SizeBits'(1);
    if (size == '0) begin
      limit_of = '0;
    end else if (size_m1 > SizeBits'(CoordMax)) begin
      limit_of = CoordMax;
    end else begin
      limit_of = size_m1[CoordBits-1:0];
    end
  endfunction

  function automatic logic [CoordBits-1:0] clamp_to(input logic signed [SumBits-1:0] v,
                                                    input logic [CoordBits-1:0] hi);
    if (v < 0) begin
      clamp_to = '0;
    end else if (v > $signed({2'b00, hi})) begin
      clamp_to = hi;
    end else begin
      clamp_to = v[CoordBits-1:0];
    end
  endfunction

  assign lim_x = limit_of(cfg_i.width);
  assign lim_y = limit_of(cfg_i.height);

  // Y grows downward, so the mouse delta is subtracted.
  assign new_x = clamp_to($signed({2'b00, pos_x_q}) + SumBits'($signed(cmd_i.dx)), lim_x);
  assign new_y = clamp_to($signed({2'b00, pos_y_q}) - SumBits'($signed(cmd_i.dy)), lim_y);

  assign fire        = cmd_valid_i && res_ready_i;
  assign move        = fire && (cmd_i.kind == CMD_MOVE);
  assign cmd_pop_o   = fire;
  assign res_valid_o = fire;

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    btn_d   = btn_q;
    if (move) begin
      pos_x_d = new_x;
      pos_y_d = new_y;
      btn_d   = cmd_i.buttons & BtnMask;
    end
    res_o.cursor_x     = pos_x_d;
    res_o.cursor_y     = pos_y_d;
    res_o.button_bits  = btn_d;
    res_o.packet_done  = (cmd_i.kind == CMD_MOVE);
    res_o.byte_dropped = (cmd_i.kind == CMD_DROP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= ResetPosX;
      pos_y_q <= ResetPosY;
      btn_q   <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      btn_q   <= btn_d;
    end
  end

  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(move) |-> (pos_x_q <= $past(lim_x)))
    else $error("cursor x left the screen after a packet");

  a_y_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(move) |-> (pos_y_q <= $past(lim_y)))
    else $error("cursor y left the screen after a packet");

  a_hold_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> ($stable(pos_x_q) && $stable(pos_y_q) && $stable(btn_q)))
    else $error("cursor changed without a completed packet");

endmodule

@@ design/ps2_mouse_packet_cursor.sv @@
// Top level of the PS/2 mouse packet cursor: queues, framer, engine and registers.
// Path: an accepted byte is registered in the command queue, then its result word in the result queue.
// Throughput: one word per cycle while neither queue is full, set by the position update in the engine.
// The command queue and the result queue each hold CMD_DEPTH words.
// Reset (rst_ni low, asynchronous) empties both queues, waits for a header byte,
// clears the buttons and centers the cursor on the 640 x 480 reset screen.
module ps2_mouse_packet_cursor #(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [11:0] cursor_x_o,
  output logic [11:0] cursor_y_o,
  output logic [2:0]  button_bits_o,
  output logic        packet_done_o,
  output logic        byte_dropped_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ps2mc_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic     byte_valid;
  logic     cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t     cmd_in, cmd_out;
  logic     res_push, res_full;
  res_t     res_in, res_out;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= ResetWidth;
      cfg_q.height <= ResetHeight;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCREEN_WIDTH:  cfg_q.width  <= pwdata[SizeBits-1:0];
        REG_SCREEN_HEIGHT: cfg_q.height <= pwdata[SizeBits-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = {{(32-SizeBits){1'b0}}, cfg_q.width};
      REG_SCREEN_HEIGHT: prdata = {{(32-SizeBits){1'b0}}, cfg_q.height};
    endcase
  end

  // Front: frame bytes into commands.
  assign full       = cmd_full;
  assign byte_valid = push && !cmd_full;

  ps2mc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (rx_byte_i),
    .cmd_valid_o  (cmd_push),
    .cmd_o        (cmd_in)
  );

  ps2mc_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back: move the cursor and queue the result words.
  ps2mc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_valid_o (res_push),
    .res_o       (res_in)
  );

  ps2mc_fifo #(
    .WIDTH (ResW),
    .DEPTH (CMD_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign cursor_x_o     = res_out.cursor_x;
  assign cursor_y_o     = res_out.cursor_y;
  assign button_bits_o  = res_out.button_bits;
  assign packet_done_o  = res_out.packet_done;
  assign byte_dropped_o = res_out.byte_dropped;

endmodule
